### hw/rtl/dqs_pkg.sv
// Shared codes and types for the deque with membership search.
// No dependencies; compiled first.
package dqs_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
        logic at_front;
        logic search;
        logic clear;
    } cmd_flags_t;

endpackage

### hw/rtl/dqs_req_if.sv
// Request channel: operation and value with valid/ready.
// No dependencies.
interface dqs_req_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            operation;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

### hw/rtl/dqs_rsp_if.sv
// Response channel: popped value, search hit, status and occupancy.
// No dependencies.
interface dqs_rsp_if #(
    parameter int VALUE_BITS = 32,
    parameter int OCC_BITS   = 7
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] result_value;
    logic                  found;
    logic [1:0]            status;
    logic [OCC_BITS-1:0]   occupancy;

    modport source (output valid, output result_value, output found, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input result_value, input found, input status,
                    input occupancy, output ready);
endinterface

### hw/rtl/dqs_front.sv
// Front end: accepts request items and decodes the operation into command flags.
// Depends on dqs_pkg.
module dqs_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [2:0]            operation,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  enq_valid,
    input  logic                  enq_ready,
    output dqs_pkg::cmd_flags_t   enq_flags,
    output logic [VALUE_BITS-1:0] enq_value
);
    import dqs_pkg::*;

    assign req_ready = enq_ready;
    assign enq_valid = req_valid;
    assign enq_value = value;

    always_comb
    begin
        enq_flags = '0;
        case (operation)
            OP_PUSH_FRONT:
            begin
                enq_flags.push     = 1'b1;
                enq_flags.at_front = 1'b1;
            end
            OP_PUSH_BACK:  enq_flags.push = 1'b1;
            OP_POP_FRONT:
            begin
                enq_flags.pop      = 1'b1;
                enq_flags.at_front = 1'b1;
            end
            OP_POP_BACK:   enq_flags.pop    = 1'b1;
            OP_SEARCH:     enq_flags.search = 1'b1;
            OP_CLEAR:      enq_flags.clear  = 1'b1;
            default:       enq_flags = '0;
        endcase
    end
endmodule

### hw/rtl/dqs_cmd_fifo.sv
// Two-entry command queue between front end and execution back end.
// No dependencies.
module dqs_cmd_fifo #(
    parameter int WIDTH = 37
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = data_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

### hw/rtl/dqs_back.sv
// Back end: ring-buffer memory, front index and count, sequential search, result register.
// Depends on dqs_pkg.
module dqs_back #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32,
    parameter int OCC_BITS   = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  dqs_pkg::cmd_flags_t   cmd_flags,
    input  logic [VALUE_BITS-1:0] cmd_value,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [VALUE_BITS-1:0] rsp_value,
    output logic                  rsp_found,
    output logic [1:0]            rsp_status,
    output logic [OCC_BITS-1:0]   rsp_occupancy
);
    import dqs_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IDX_W:0]    CAP_W = (IDX_W + 1)'(CAPACITY);
    localparam logic [OCC_BITS-1:0] CAP_C = OCC_BITS'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    logic [VALUE_BITS-1:0] mem [CAPACITY];

    logic [1:0]            state_reg, state_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [OCC_BITS-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]      cmp_reg, cmp_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [VALUE_BITS-1:0] rd_data_reg;

    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_found_reg;
    logic [1:0]            out_status_reg;
    logic [OCC_BITS-1:0]   out_occ_reg;

    logic                  slot_free, out_load;
    logic [VALUE_BITS-1:0] out_value_n;
    logic                  out_found_n;
    logic [1:0]            out_status_n;
    logic                  rd_en, wr_en;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    logic                  hit, last;

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= CAP_W)
        begin
            sum = sum - CAP_W;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign slot_free = !out_valid_reg || rsp_ready;
    assign hit       = (rd_data_reg == key_reg);
    assign last      = ((IDX_W + 1)'(cmp_reg) + 1'b1) == (IDX_W + 1)'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        cmp_next     = cmp_reg;
        key_next     = key_reg;
        cmd_pop      = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = front_reg;
        wr_en        = 1'b0;
        wr_addr      = front_reg;
        out_load     = 1'b0;
        out_value_n  = '0;
        out_found_n  = 1'b0;
        out_status_n = STAT_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_flags.push)
                    begin
                        out_load = 1'b1;
                        if (count_reg == CAP_C)
                        begin
                            out_status_n = STAT_FULL;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            if (cmd_flags.at_front)
                            begin
                                wr_addr    = wrap(front_reg, CAP_W - 1'b1);
                                front_next = wr_addr;
                            end
                            else
                            begin
                                wr_addr = wrap(front_reg, (IDX_W + 1)'(count_reg));
                            end
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (cmd_flags.pop)
                    begin
                        if (count_reg == '0)
                        begin
                            out_load     = 1'b1;
                            out_value_n  = '1;
                            out_status_n = STAT_EMPTY;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                            if (cmd_flags.at_front)
                            begin
                                rd_addr    = front_reg;
                                front_next = wrap(front_reg, (IDX_W + 1)'(1));
                            end
                            else
                            begin
                                rd_addr = wrap(front_reg,
                                               (IDX_W + 1)'(count_reg) - 1'b1);
                            end
                            count_next = count_reg - 1'b1;
                            state_next = S_POP;
                        end
                    end
                    else if (cmd_flags.search)
                    begin
                        if (count_reg == '0)
                        begin
                            out_load = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = front_reg;
                            cmp_next   = '0;
                            key_next   = cmd_value;
                            state_next = S_SRCH;
                        end
                    end
                    else if (cmd_flags.clear)
                    begin
                        out_load   = 1'b1;
                        count_next = '0;
                        front_next = '0;
                    end
                    else
                    begin
                        out_load = 1'b1;
                    end
                end
            end
            S_POP:
            begin
                if (slot_free)
                begin
                    out_load    = 1'b1;
                    out_value_n = rd_data_reg;
                    state_next  = S_IDLE;
                end
            end
            S_SRCH:
            begin
                if (hit || last)
                begin
                    if (slot_free)
                    begin
                        out_load    = 1'b1;
                        out_found_n = hit;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    cmp_next = cmp_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = wrap(front_reg, (IDX_W + 1)'(cmp_reg) + 1'b1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_reg <= cmp_next;
        key_reg <= key_next;
        if (out_load)
        begin
            out_value_reg  <= out_value_n;
            out_found_reg  <= out_found_n;
            out_status_reg <= out_status_n;
            out_occ_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign rsp_value     = out_value_reg;
    assign rsp_found     = out_found_reg;
    assign rsp_status    = out_status_reg;
    assign rsp_occupancy = out_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd_pop)
        else $error("command taken while back end busy");

    a_empty_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STAT_EMPTY) |->
            (out_value_reg == '1 && out_occ_reg == '0))
        else $error("empty pop result malformed");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_found_reg) |->
            (out_status_reg == STAT_OK && out_value_reg == '0 && out_occ_reg != '0))
        else $error("search hit with bad fields");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STAT_FULL) |-> (out_occ_reg == CAP_C))
        else $error("full status below capacity");
endmodule

### hw/rtl/deque_with_membership_search_unit.sv
// Top level of the deque with membership search: front end, command queue, back end.
// Depends on dqs_pkg, dqs_req_if, dqs_rsp_if, dqs_front, dqs_cmd_fifo, dqs_back.
//
//  channel | role   | payload
//  req     | sink   | operation[2:0], value[VALUE_BITS-1:0]
//  rsp     | source | result_value, found, status[1:0], occupancy
//
// Items enter a two-entry command queue; one result is registered per item.
// Push, clear, no-op, empty pop and empty search load the result register from the idle state.
// Pop reads memory, then loads the result; search reads one ring-buffer entry per cycle up to a hit or the last entry.
// rst_n clears indexes, count and valid flags asynchronously; entry memory is not cleared.
// A stalled rsp holds the result register and the back end at its next result; req stalls when the queue is full.
module deque_with_membership_search_unit #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input logic      clk,
    input logic      rst_n,
    dqs_req_if.sink  req,
    dqs_rsp_if.source rsp
);
    import dqs_pkg::*;

    localparam int OCC_BITS = $clog2(CAPACITY + 1);
    localparam int CMD_W    = $bits(cmd_flags_t) + VALUE_BITS;

    logic                  enq_valid, enq_ready;
    cmd_flags_t            enq_flags;
    logic [VALUE_BITS-1:0] enq_value;
    logic                  deq_valid, deq_pop;
    logic [CMD_W-1:0]      deq_data;
    cmd_flags_t            deq_flags;
    logic [VALUE_BITS-1:0] deq_value;

    dqs_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .req_valid (req.valid),
        .req_ready (req.ready),
        .operation (req.operation),
        .value     (req.value),
        .enq_valid (enq_valid),
        .enq_ready (enq_ready),
        .enq_flags (enq_flags),
        .enq_value (enq_value)
    );

    dqs_cmd_fifo #(
        .WIDTH(CMD_W)
    ) u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (enq_valid),
        .push_ready (enq_ready),
        .push_data  ({enq_flags, enq_value}),
        .pop_valid  (deq_valid),
        .pop        (deq_pop),
        .pop_data   (deq_data)
    );

    assign {deq_flags, deq_value} = deq_data;

    dqs_back #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .OCC_BITS   (OCC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (deq_valid),
        .cmd_pop       (deq_pop),
        .cmd_flags     (deq_flags),
        .cmd_value     (deq_value),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_value     (rsp.result_value),
        .rsp_found     (rsp.found),
        .rsp_status    (rsp.status),
        .rsp_occupancy (rsp.occupancy)
    );
endmodule
